>>> design/pksa_pkg.sv
// ----------------------------------------------------------------------------
// pksa_pkg
// Shared widths, operation codes and parameter defaults of the per-key
// sequence allocator.
// ----------------------------------------------------------------------------
package pksa_pkg;

    // Payload widths of the request and response channels.
    localparam int KEY_ID_BITS      = 12;
    localparam int SEQ_BITS         = 64;
    localparam int SECTION_OUT_BITS = 8;

    // Defaults for the top-level parameters.
    localparam int KEY_BITS_DEF      = 12;
    localparam int SECTION_SHIFT_DEF = 4;
    localparam int SEQ_STEP_DEF      = 10000;

    // Operation codes carried in the op field.
    localparam logic OP_FETCH = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef logic [SEQ_BITS-1:0] t_seq;

endpackage

>>> design/pksa_if.sv
// ----------------------------------------------------------------------------
// pksa_if
// Valid/ready channels of the allocator: requests in, responses out.
// ----------------------------------------------------------------------------
interface pksa_req_if import pksa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [KEY_ID_BITS-1:0] key_id;

    modport source (output valid, output op, output key_id, input ready);
    modport sink   (input valid, input op, input key_id, output ready);
endinterface

interface pksa_rsp_if import pksa_pkg::*; ();
    logic                        valid;
    logic                        ready;
    t_seq                        sequence_res;
    logic                        persist_valid;
    logic [SECTION_OUT_BITS-1:0] persist_section;
    t_seq                        persist_ceiling;

    modport source (output valid, output sequence_res, output persist_valid,
                    output persist_section, output persist_ceiling, input ready);
    modport sink   (input valid, input sequence_res, input persist_valid,
                    input persist_section, input persist_ceiling, output ready);
endinterface

>>> design/pksa_ram.sv
// ----------------------------------------------------------------------------
// pksa_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (old data on a same-address write).
// ----------------------------------------------------------------------------
module pksa_ram #(
    parameter int DATA_BITS = 64,
    parameter int ADDR_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    localparam int DEPTH = 2 ** ADDR_BITS;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/per_key_sequence_allocator.sv
// ----------------------------------------------------------------------------
// per_key_sequence_allocator
// Per-key 64-bit sequence counters with reserved ceilings per key section.
//
// Usage:
//   i_req carries one transaction per request: op (fetch or read) and key_id.
//   o_rsp returns one transaction per request, in order: the new or current
//   counter, and a persist record (section, new ceiling) when a fetch pushed
//   the counter past its section's reserved ceiling.
//   The response passes through the read stage into the output register,
//   from which it is taken. Throughput is one request per cycle while the
//   receiver keeps o_rsp.ready high, also for consecutive requests on the
//   same key or section: the counter and ceiling memories are read when a
//   request is accepted and written back when it leaves the read stage,
//   and the last write of each memory is forwarded to the next read.
//   After reset the block sweeps both memories to zero, one entry per
//   cycle, over all 2**KEY_BITS counter entries (4096 by default);
//   i_req.ready stays low meanwhile. When the receiver holds o_rsp.ready
//   low, the response waits in the output register, one more request waits
//   in the read stage, and i_req.ready drops until the output register drains.
// ----------------------------------------------------------------------------
module per_key_sequence_allocator import pksa_pkg::*; #(
    parameter int KEY_BITS      = KEY_BITS_DEF,
    parameter int SECTION_SHIFT = SECTION_SHIFT_DEF,
    parameter int SEQ_STEP      = SEQ_STEP_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pksa_req_if.sink   i_req,
    pksa_rsp_if.source o_rsp
);

    localparam int SEC_BITS = (KEY_BITS > SECTION_SHIFT) ? (KEY_BITS - SECTION_SHIFT) : 1;
    // Distance from an exhausted ceiling to the next one. With a step of one the
    // next multiple strictly above ceiling + 1 is ceiling + 2.
    localparam int STEP_INC = (SEQ_STEP == 1) ? 2 : SEQ_STEP;
    localparam logic [SEQ_BITS:0] STEP_EXT = (SEQ_BITS + 1)'(STEP_INC);

    // Clearing sweep.
    logic                r_clr_busy;
    logic [KEY_BITS-1:0] r_clr_addr;

    // Read stage: request whose memory data is on the RAM outputs.
    logic                r_s1_vld;
    logic                r_s1_op;
    logic [KEY_BITS-1:0] r_s1_key;

    // Forwarding of the most recent write to each memory.
    logic                r_fwd_vld;
    logic [KEY_BITS-1:0] r_fwd_key;
    t_seq                r_fwd_cnt;
    logic                r_sfwd_vld;
    logic [SEC_BITS-1:0] r_sfwd_sec;
    t_seq                r_sfwd_ceil;

    // Output register.
    logic                        r_out_vld;
    t_seq                        r_out_seq;
    logic                        r_out_pv;
    logic [SECTION_OUT_BITS-1:0] r_out_psec;
    t_seq                        r_out_pceil;

    logic                accept;
    logic                s1_move;
    logic [KEY_BITS-1:0] in_key;
    logic [SEC_BITS-1:0] in_sec;
    logic [SEC_BITS-1:0] s1_sec;
    t_seq                cnt_rdata;
    t_seq                ceil_rdata;
    t_seq                cur_cnt;
    t_seq                cur_ceil;
    t_seq                seq_next;
    logic                is_fetch;
    logic                raise;
    logic [SEQ_BITS:0]   ceil_sum;
    t_seq                ceil_next;

    logic                cnt_we;
    logic [KEY_BITS-1:0] cnt_waddr;
    t_seq                cnt_wdata;
    logic                ceil_we;
    logic [SEC_BITS-1:0] ceil_waddr;
    t_seq                ceil_wdata;

    // Handshake and request decode.
    assign s1_move     = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_clr_busy && (!r_s1_vld || s1_move);
    assign accept      = i_req.valid && i_req.ready;
    assign in_key      = KEY_BITS'(i_req.key_id);
    assign in_sec      = SEC_BITS'(in_key >> SECTION_SHIFT);
    assign s1_sec      = SEC_BITS'(r_s1_key >> SECTION_SHIFT);

    // Current values, taking the last write back when it hit the same entry.
    assign cur_cnt  = (r_fwd_vld && (r_fwd_key == r_s1_key)) ? r_fwd_cnt : cnt_rdata;
    assign cur_ceil = (r_sfwd_vld && (r_sfwd_sec == s1_sec)) ? r_sfwd_ceil : ceil_rdata;

    // A counter never exceeds its section's ceiling, and ceilings are multiples
    // of the step (or saturated), so a raise only happens when the new value is
    // ceiling + 1; the next multiple above it is then ceiling + STEP_INC.
    assign is_fetch  = (r_s1_op == OP_FETCH);
    assign seq_next  = cur_cnt + t_seq'(1);
    assign raise     = is_fetch && (cur_cnt >= cur_ceil) && (cur_cnt != '1);
    assign ceil_sum  = {1'b0, cur_ceil} + STEP_EXT;
    assign ceil_next = ceil_sum[SEQ_BITS] ? '1 : ceil_sum[SEQ_BITS-1:0];

    // Memory write ports: the clearing sweep, then write-back of the read stage.
    always_comb begin
        if (r_clr_busy) begin
            cnt_we     = 1'b1;
            cnt_waddr  = r_clr_addr;
            cnt_wdata  = '0;
            ceil_we    = 1'b1;
            ceil_waddr = SEC_BITS'(r_clr_addr);
            ceil_wdata = '0;
        end else begin
            cnt_we     = s1_move && is_fetch;
            cnt_waddr  = r_s1_key;
            cnt_wdata  = seq_next;
            ceil_we    = s1_move && raise;
            ceil_waddr = s1_sec;
            ceil_wdata = ceil_next;
        end
    end

    pksa_ram #(
        .DATA_BITS (SEQ_BITS),
        .ADDR_BITS (KEY_BITS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (accept),
        .i_raddr (in_key),
        .o_rdata (cnt_rdata)
    );

    pksa_ram #(
        .DATA_BITS (SEQ_BITS),
        .ADDR_BITS (SEC_BITS)
    ) u_ceil_ram (
        .i_clk   (i_clk),
        .i_we    (ceil_we),
        .i_waddr (ceil_waddr),
        .i_wdata (ceil_wdata),
        .i_re    (accept),
        .i_raddr (in_sec),
        .o_rdata (ceil_rdata)
    );

    // Clearing sweep after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + KEY_BITS'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Read stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op  <= i_req.op;
            r_s1_key <= in_key;
        end
    end

    // Forwarding registers follow the most recent write of each memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld  <= 1'b0;
            r_sfwd_vld <= 1'b0;
        end else begin
            if (!r_clr_busy && cnt_we) begin
                r_fwd_vld <= 1'b1;
            end
            if (!r_clr_busy && ceil_we) begin
                r_sfwd_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clr_busy && cnt_we) begin
            r_fwd_key <= r_s1_key;
            r_fwd_cnt <= seq_next;
        end
        if (!r_clr_busy && ceil_we) begin
            r_sfwd_sec  <= s1_sec;
            r_sfwd_ceil <= ceil_next;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_seq   <= is_fetch ? seq_next : cur_cnt;
            r_out_pv    <= raise;
            r_out_psec  <= raise ? SECTION_OUT_BITS'(s1_sec) : '0;
            r_out_pceil <= raise ? ceil_next : '0;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.sequence_res    = r_out_seq;
    assign o_rsp.persist_valid   = r_out_pv;
    assign o_rsp.persist_section = r_out_psec;
    assign o_rsp.persist_ceiling = r_out_pceil;

`ifndef SYNTHESIS
    // The read stage is empty for as long as the memories are being cleared.
    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_vld)
        else $error("request in the read stage during the clearing sweep");

    // The sweep ends only after it has wrapped over every counter entry.
    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> (r_clr_addr == '0))
        else $error("clearing sweep ended before covering the memory");

    // A raised ceiling always lies strictly above the sequence it covers.
    a_ceiling_above_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.persist_valid) |->
            (o_rsp.persist_ceiling > o_rsp.sequence_res))
        else $error("persist record with a ceiling not above the sequence");

    // A ceiling is raised only by a fetch that actually retires.
    a_raise_on_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clr_busy && ceil_we) |-> (r_s1_vld && is_fetch && s1_move))
        else $error("ceiling write without a retiring fetch");
`endif

endmodule
